/* hdl/ett_pkg.sv */
// Shared types, codes and field layout for the expiring token table.
package ett_pkg;

  // Default sizing
  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 64;

  // Field widths
  localparam int OP_W      = 3;
  localparam int KEY_W     = 64;
  localparam int OWNER_W   = 64;
  localparam int NOW_W     = 32;
  localparam int LIFE_W    = 24;
  localparam int STATUS_W  = 2;
  localparam int ENTRIES_W = 5;

  // Input tdata layout, lowest bit first
  localparam int IN_OP_LSB   = 0;
  localparam int IN_KEY_LSB  = IN_OP_LSB + OP_W;
  localparam int IN_NKEY_LSB = IN_KEY_LSB + KEY_W;
  localparam int IN_OHI_LSB  = IN_NKEY_LSB + KEY_W;
  localparam int IN_OLO_LSB  = IN_OHI_LSB + OWNER_W;
  localparam int IN_NOW_LSB  = IN_OLO_LSB + OWNER_W;
  localparam int IN_BITS     = IN_NOW_LSB + NOW_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // Output tdata layout, lowest bit first
  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_FHI_LSB    = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_FLO_LSB    = OUT_FHI_LSB + OWNER_W;
  localparam int OUT_USED_LSB   = OUT_FLO_LSB + OWNER_W;
  localparam int OUT_BITS       = OUT_USED_LSB + ENTRIES_W;
  localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CREATE   = 3'd0;
  localparam logic [OP_W-1:0] OP_VALIDATE = 3'd1;
  localparam logic [OP_W-1:0] OP_ROTATE   = 3'd2;
  localparam logic [OP_W-1:0] OP_REVOKE   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEANUP  = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // Configuration port
  localparam int                 CFG_ADDR_W   = 3;
  localparam int                 CFG_DATA_W   = 32;
  localparam logic [0:0]         REG_LIFETIME = 1'b0;
  localparam logic [LIFE_W-1:0]  LIFETIME_RST = 24'd2592000;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_APPEND,
    S_RESP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic scan;
    logic append;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            scan_done;
  } dp_sts_t;

endpackage

/* hdl/expiring_token_table_core.sv */
// Top level of the expiring token table: configuration register, sequencer and datapath.
//
// An ordered table of token keys with owner ids and expiry times. One operation
// enters per input transaction (create, validate, rotate, revoke, cleanup) and
// gives exactly one result transaction: status, matched owner, entries in use.
// Both channels handshake on tvalid and tready. The lifetime register is written through
// the APB port (byte address 0); keeping the block idle then is left to the user.
//
// Sequence: a transaction is taken in the idle state and decoded in the
// dispatch state. Create then appends unless the table is full. The other
// operations scan the entry memory one entry per cycle (single read port,
// registered read data); rotate then passes through the append step, which
// writes only if the token was found. The result enters the output register
// in the response state, and input is taken again once the sequencer is back
// in the idle state.
//
// The result sits in an output register; while the receiver stalls the block
// still accepts and works on the next transaction, then waits until that
// register frees. Reset empties the table and restores the default lifetime;
// memory contents are left as they are, as only stored entries are ever read.
module expiring_token_table_core #(
  parameter int DEPTH    = ett_pkg::DEPTH_DEF,
  parameter int KEY_BITS = ett_pkg::KEY_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // op, token_key, new_key, owner_hi, owner_lo, now_seconds (low bit first)
  input  logic [ett_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status, found_owner_hi, found_owner_lo, entries_used (low bit first)
  output logic [ett_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ett_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [ett_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [ett_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  logic [ett_pkg::LIFE_W-1:0] lifetime_r, lifetime_nxt;
  logic                       sel_lifetime;
  ett_pkg::dp_cmd_t           cmd;
  ett_pkg::dp_sts_t           sts;

  // Configuration register
  assign cfg_pready   = 1'b1;
  assign sel_lifetime = (cfg_paddr[ett_pkg::CFG_ADDR_W-1:2] == ett_pkg::REG_LIFETIME);

  always_comb begin
    lifetime_nxt = lifetime_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_lifetime) begin
      lifetime_nxt = cfg_pwdata[ett_pkg::LIFE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= ett_pkg::LIFETIME_RST;
    end else begin
      lifetime_r <= lifetime_nxt;
    end
  end

  assign cfg_prdata = sel_lifetime ?
                      {{(ett_pkg::CFG_DATA_W - ett_pkg::LIFE_W){1'b0}}, lifetime_r} : '0;

  ett_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ett_dp #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .lifetime  (lifetime_r),
    .out_tdata (out_tdata)
  );

endmodule

/* hdl/ett_ctrl.sv */
// Sequencer for the token table: dispatches an operation, runs the scan and append steps.
module ett_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  ett_pkg::dp_sts_t sts,
  output ett_pkg::dp_cmd_t cmd
);

  ett_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ett_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ett_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ett_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ett_pkg::S_DISPATCH;
        end
      end
      ett_pkg::S_DISPATCH: begin
        case (sts.op)
          ett_pkg::OP_CREATE:   state_nxt = sts.full ? ett_pkg::S_RESP : ett_pkg::S_APPEND;
          ett_pkg::OP_VALIDATE: state_nxt = ett_pkg::S_SCAN;
          ett_pkg::OP_ROTATE:   state_nxt = ett_pkg::S_SCAN;
          ett_pkg::OP_REVOKE:   state_nxt = ett_pkg::S_SCAN;
          ett_pkg::OP_CLEANUP:  state_nxt = ett_pkg::S_SCAN;
          default:              state_nxt = ett_pkg::S_RESP;
        endcase
      end
      ett_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = (sts.op == ett_pkg::OP_ROTATE) ? ett_pkg::S_APPEND : ett_pkg::S_RESP;
        end
      end
      ett_pkg::S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = ett_pkg::S_RESP;
      end
      ett_pkg::S_RESP: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ett_pkg::S_IDLE;
        end
      end
      default: state_nxt = ett_pkg::S_IDLE;
    endcase
  end

endmodule

/* hdl/ett_dp.sv */
// Datapath of the token table: entry memory, compaction scan, append and result register.
module ett_dp #(
  parameter int DEPTH    = ett_pkg::DEPTH_DEF,
  parameter int KEY_BITS = ett_pkg::KEY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ett_pkg::dp_cmd_t                  cmd,
  output ett_pkg::dp_sts_t                  sts,
  input  logic [ett_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [ett_pkg::LIFE_W-1:0]        lifetime,
  output logic [ett_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam int OW = ett_pkg::OWNER_W;
  localparam int NW = ett_pkg::NOW_W;

  // Entry memory
  logic [KEY_BITS-1:0] key_mem [DEPTH];
  logic [OW-1:0]       ohi_mem [DEPTH];
  logic [OW-1:0]       olo_mem [DEPTH];
  logic [NW-1:0]       exp_mem [DEPTH];

  // Current transaction
  logic [ett_pkg::OP_W-1:0] op_r;
  logic [KEY_BITS-1:0]      key_r, nkey_r;
  logic [OW-1:0]            ohi_r, olo_r;
  logic [NW-1:0]            now_r;

  // Scan control
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] wr_idx_r, wr_idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             found_r, found_nxt;
  logic             full_r, full_nxt;
  logic [OW-1:0]    fhi_r, fhi_nxt, flo_r, flo_nxt;
  logic [ett_pkg::OUT_TDATA_W-1:0] out_r, out_nxt;

  // Registered read data
  logic [KEY_BITS-1:0] rd_key_r;
  logic [OW-1:0]       rd_ohi_r, rd_olo_r;
  logic [NW-1:0]       rd_exp_r;

  // Memory port controls
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [KEY_BITS-1:0] mem_wkey;
  logic [OW-1:0]       mem_wohi, mem_wolo;
  logic [NW-1:0]       mem_wexp;

  logic                match, live, drop, capture, scan_done, do_append;
  logic [NW:0]         exp_sum;
  logic [NW-1:0]       exp_new;
  logic [ett_pkg::STATUS_W-1:0] status;
  logic [CNT_W+ett_pkg::ENTRIES_W-1:0] used_ext;

  // Transaction capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r   <= in_tdata[ett_pkg::IN_OP_LSB +: ett_pkg::OP_W];
      key_r  <= in_tdata[ett_pkg::IN_KEY_LSB +: KEY_BITS];
      nkey_r <= in_tdata[ett_pkg::IN_NKEY_LSB +: KEY_BITS];
      ohi_r  <= in_tdata[ett_pkg::IN_OHI_LSB +: OW];
      olo_r  <= in_tdata[ett_pkg::IN_OLO_LSB +: OW];
      now_r  <= in_tdata[ett_pkg::IN_NOW_LSB +: NW];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_idx_r <= '0;
      wr_idx_r <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
      full_r   <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
      rd_vld_r <= rd_vld_nxt;
      found_r  <= found_nxt;
      full_r   <= full_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    fhi_r <= fhi_nxt;
    flo_r <= flo_nxt;
    out_r <= out_nxt;
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_waddr] <= mem_wkey;
      ohi_mem[mem_waddr] <= mem_wohi;
      olo_mem[mem_waddr] <= mem_wolo;
      exp_mem[mem_waddr] <= mem_wexp;
    end
  end

  // Memory read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_ohi_r <= ohi_mem[rd_addr];
      rd_olo_r <= olo_mem[rd_addr];
      rd_exp_r <= exp_mem[rd_addr];
    end
  end

  // Saturating expiry for a new entry
  assign exp_sum = {1'b0, now_r} + {{(NW + 1 - ett_pkg::LIFE_W){1'b0}}, lifetime};
  assign exp_new = exp_sum[NW] ? {NW{1'b1}} : exp_sum[NW-1:0];

  assign match     = (rd_key_r == key_r);
  assign live      = (rd_exp_r > now_r);
  assign scan_done = (rd_idx_r >= count_r);
  assign do_append = cmd.append && ((op_r != ett_pkg::OP_ROTATE) || found_r);

  // Keep/drop decision for the entry under the scan
  always_comb begin
    drop    = 1'b0;
    capture = 1'b0;
    case (op_r)
      ett_pkg::OP_VALIDATE: capture = !found_r && match && live;
      ett_pkg::OP_ROTATE: begin
        capture = !found_r && match && live;
        drop    = capture;
      end
      ett_pkg::OP_REVOKE:  drop = !found_r && match;
      ett_pkg::OP_CLEANUP: drop = !live;
      default: drop = 1'b0;
    endcase
  end

  // Result status
  always_comb begin
    case (op_r)
      ett_pkg::OP_CREATE:   status = full_r ? ett_pkg::ST_FULL : ett_pkg::ST_OK;
      ett_pkg::OP_VALIDATE: status = found_r ? ett_pkg::ST_OK : ett_pkg::ST_NOT_FOUND;
      ett_pkg::OP_ROTATE:   status = found_r ? ett_pkg::ST_OK : ett_pkg::ST_NOT_FOUND;
      ett_pkg::OP_REVOKE:   status = found_r ? ett_pkg::ST_OK : ett_pkg::ST_NOT_FOUND;
      default:              status = ett_pkg::ST_OK;
    endcase
  end

  assign used_ext = {{ett_pkg::ENTRIES_W{1'b0}}, count_r};

  // Next-state logic for scan, append and result
  always_comb begin
    count_nxt  = count_r;
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    rd_vld_nxt = 1'b0;
    found_nxt  = found_r;
    full_nxt   = full_r;
    fhi_nxt    = fhi_r;
    flo_nxt    = flo_r;
    out_nxt    = out_r;
    rd_en      = 1'b0;
    rd_addr    = rd_idx_r[IDX_W-1:0];
    mem_we     = 1'b0;
    mem_waddr  = wr_idx_r[IDX_W-1:0];
    mem_wkey   = rd_key_r;
    mem_wohi   = rd_ohi_r;
    mem_wolo   = rd_olo_r;
    mem_wexp   = rd_exp_r;

    if (cmd.load_item) begin
      rd_idx_nxt = '0;
      wr_idx_nxt = '0;
      found_nxt  = 1'b0;
      full_nxt   = (count_r >= DEPTH_CNT);
      fhi_nxt    = '0;
      flo_nxt    = '0;
    end

    // One entry read per cycle; the previous read is kept or dropped
    if (cmd.scan) begin
      rd_en      = !scan_done;
      rd_vld_nxt = rd_en;
      if (rd_en) begin
        rd_idx_nxt = rd_idx_r + CNT_W'(1);
      end
      if (rd_vld_r) begin
        if (drop) begin
          found_nxt = 1'b1;
        end else begin
          mem_we     = 1'b1;
          wr_idx_nxt = wr_idx_r + CNT_W'(1);
        end
        // first live match only: later matches are ignored
        if (capture) begin
          found_nxt = 1'b1;
          fhi_nxt   = rd_ohi_r;
          flo_nxt   = rd_olo_r;
        end
      end
      if (scan_done) begin
        count_nxt = wr_idx_nxt;
      end
    end

    // Append at the end of the table
    if (do_append) begin
      mem_we    = 1'b1;
      mem_waddr = count_r[IDX_W-1:0];
      mem_wkey  = (op_r == ett_pkg::OP_ROTATE) ? nkey_r : key_r;
      mem_wohi  = (op_r == ett_pkg::OP_ROTATE) ? fhi_r : ohi_r;
      mem_wolo  = (op_r == ett_pkg::OP_ROTATE) ? flo_r : olo_r;
      mem_wexp  = exp_new;
      count_nxt = count_r + CNT_W'(1);
    end

    if (cmd.load_out) begin
      out_nxt = '0;
      out_nxt[ett_pkg::OUT_STATUS_LSB +: ett_pkg::STATUS_W] = status;
      out_nxt[ett_pkg::OUT_FHI_LSB +: OW] = fhi_r;
      out_nxt[ett_pkg::OUT_FLO_LSB +: OW] = flo_r;
      out_nxt[ett_pkg::OUT_USED_LSB +: ett_pkg::ENTRIES_W] = used_ext[ett_pkg::ENTRIES_W-1:0];
    end
  end

  assign sts.op        = op_r;
  assign sts.full      = full_r;
  assign sts.scan_done = scan_done;
  assign out_tdata     = out_r;

endmodule
